>>> hdl/cpusch_pkg.sv
// Shared types, codes and constants of the CPU scheduler tick engine.
package cpusch_pkg;

    localparam int NUM_PROCS_DEF = 16;
    localparam int TDATA_IN_W    = 48;
    localparam int TDATA_OUT_W   = 64;
    localparam int CFG_DATA_W    = 8;
    localparam int CFG_IDX_W     = 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SLICE_LEN  = 1'b1;

    localparam logic [2:0] MODE_FCFS  = 3'd0;
    localparam logic [2:0] MODE_SJF   = 3'd1;
    localparam logic [2:0] MODE_PRIO  = 3'd2;
    localparam logic [2:0] MODE_RR    = 3'd3;
    localparam logic [2:0] MODE_PSJF  = 3'd4;
    localparam logic [2:0] MODE_PPRIO = 3'd5;

    localparam logic [7:0] QUANT_RESET = 8'd2;

    typedef enum logic [2:0] {
        PS_EMPTY,
        PS_PENDING,
        PS_READY,
        PS_RUN,
        PS_IO,
        PS_DONE
    } pstat_t;

    typedef enum logic [1:0] {
        OC_NONE,
        OC_IO,
        OC_PREEMPT
    } outcome_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_CLR,
        OP_FIND,
        OP_LOAD,
        OP_ARR_RD,
        OP_ARR_CHK,
        OP_SEL_RD,
        OP_SEL_CHK,
        OP_SEL_TAKE,
        OP_RUN_RD,
        OP_RUN_EX,
        OP_IO_RD,
        OP_IO_CHK,
        OP_POST,
        OP_OUT
    } dp_op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_FIND,
        S_LOAD,
        S_ARR_RD,
        S_ARR_CHK,
        S_SEL_RD,
        S_SEL_CHK,
        S_SEL_TAKE,
        S_RUN_RD,
        S_RUN_EX,
        S_IO_RD,
        S_IO_CHK,
        S_POST,
        S_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic is_tick;
        logic idx_ok;
        logic idx_queued;
        logic find_hit;
        logic scan_last;
        logic run_valid;
        logic ready_empty;
        logic sel_last;
        logic io_end;
        logic out_free;
    } sta_t;

    typedef struct packed {
        logic [7:0] arr;
        logic [7:0] cpu;
        logic [7:0] iob;
        logic [7:0] req;
        logic [7:0] prio;
    } tbl_row_t;

    typedef struct packed {
        logic [7:0] rem;
        logic [7:0] req_left;
        logic [7:0] io_left;
        logic       io_taken;
    } dyn_row_t;

endpackage

>>> hdl/cpusch_ram.sv
// Generic single write port RAM with one registered read port.
module cpusch_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hdl/cpusch_queue.sv
// Compacting slot queue: push at tail, take from any position, indexed read.
module cpusch_queue #(
    parameter int DEPTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [$clog2(DEPTH)-1:0]   push_data,
    input  logic                       take,
    input  logic [$clog2(DEPTH)-1:0]   take_pos,
    input  logic [$clog2(DEPTH)-1:0]   rd_pos,
    output logic [$clog2(DEPTH)-1:0]   rd_data,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [SW-1:0] cell_reg [DEPTH];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    // take and push never land in the same cycle
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
            begin
                if (SW'(k) >= take_pos)
                begin
                    cell_reg[k] <= cell_reg[k + 1];
                end
            end
        end
        else if (push && (count_reg < CW'(DEPTH)))
        begin
            cell_reg[count_reg[SW-1:0]] <= push_data;
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (take)
        begin
            count_next = count_reg - CW'(1);
        end
        else if (push && (count_reg < CW'(DEPTH)))
        begin
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign rd_data = cell_reg[rd_pos];
    assign count   = count_reg;

endmodule

>>> hdl/cpusch_dp.sv
// Datapath: process table, slot state, queues, clock and result register.
module cpusch_dp #(
    parameter int NUM_PROCS = cpusch_pkg::NUM_PROCS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  cpusch_pkg::dp_op_t                     op,
    output cpusch_pkg::sta_t                       sta,
    input  logic                                   cfg_we,
    input  logic [cpusch_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [cpusch_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                   in_accept,
    input  logic                                   in_kind,
    input  logic [cpusch_pkg::TDATA_IN_W-1:0]      in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic                                   out_flag,
    output logic [cpusch_pkg::TDATA_OUT_W-1:0]     out_data
);
    import cpusch_pkg::*;

    localparam int SW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);

    // configuration
    logic [2:0] mode_reg, mode_next;
    logic [7:0] quant_reg, quant_next;
    logic [2:0] mode_eff;
    logic [7:0] quant_eff;

    // captured item
    logic       kind_reg;
    logic [3:0] pidx_reg;
    logic [7:0] arr_in_reg, cpu_in_reg, iob_in_reg, req_in_reg, prio_in_reg;

    // control state
    pstat_t        status_reg [NUM_PROCS];
    pstat_t        status_next [NUM_PROCS];
    logic [15:0]   tick_reg, tick_next;
    logic          run_valid_reg, run_valid_next;
    logic [SW-1:0] run_slot_reg, run_slot_next;
    logic [7:0]    slice_reg, slice_next;
    logic [CW-1:0] loaded_reg, loaded_next;
    logic [CW-1:0] done_reg, done_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic          out_valid_reg, out_valid_next;

    // working payload
    logic [SW-1:0] best_pos_reg, best_pos_next;
    logic [7:0]    best_key_reg, best_key_next;
    logic [4:0]    ran_reg, ran_next;
    logic          dflag_reg, dflag_next;
    logic [4:0]    dpid_reg, dpid_next;
    logic [15:0]   tat_reg, tat_next;
    logic [15:0]   wait_reg, wait_next;
    outcome_t      outcome_reg, outcome_next;
    logic [7:0]    srem_reg, srem_next;
    logic [7:0]    srl_reg, srl_next;
    logic [7:0]    siob_reg, siob_next;
    logic          out_flag_reg, out_flag_next;
    logic [TDATA_OUT_W-1:0] out_data_reg, out_data_next;

    // memories
    logic                  tbl_we, dyn_we;
    logic [SW-1:0]         tbl_waddr, tbl_raddr, dyn_waddr, dyn_raddr;
    tbl_row_t              tbl_wrow, tbl_rd;
    dyn_row_t              dyn_wrow, dyn_rd;
    logic [$bits(tbl_row_t)-1:0] tbl_rdata;
    logic [$bits(dyn_row_t)-1:0] dyn_rdata;

    // queues
    logic          rq_push, rq_take, iq_push, iq_take;
    logic [SW-1:0] rq_push_data, rq_take_pos, rq_rd_pos, rq_rd_data;
    logic [SW-1:0] iq_push_data, iq_take_pos, iq_rd_data;
    logic [CW-1:0] rq_count, iq_count;

    // derived values
    logic [SW-1:0] slot_ld, scan_slot;
    logic          idx_ok;
    logic [7:0]    cpu_fix, req_fix, sel_key;
    logic [7:0]    rem_n, rl_n, slice_inc, il_n;
    logic [15:0]   tick_inc, arr_ext, tat_c, wait_c;
    logic [8:0]    used_c;
    logic [4:0]    run_pid;
    logic          all_done;

    cpusch_ram #(.WIDTH($bits(tbl_row_t)), .DEPTH(NUM_PROCS)) u_tbl_ram (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wrow),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    cpusch_ram #(.WIDTH($bits(dyn_row_t)), .DEPTH(NUM_PROCS)) u_dyn_ram (
        .clk   (clk),
        .we    (dyn_we),
        .waddr (dyn_waddr),
        .wdata (dyn_wrow),
        .raddr (dyn_raddr),
        .rdata (dyn_rdata)
    );

    cpusch_queue #(.DEPTH(NUM_PROCS)) u_ready_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rq_push),
        .push_data (rq_push_data),
        .take      (rq_take),
        .take_pos  (rq_take_pos),
        .rd_pos    (rq_rd_pos),
        .rd_data   (rq_rd_data),
        .count     (rq_count)
    );

    cpusch_queue #(.DEPTH(NUM_PROCS)) u_io_q (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (iq_push),
        .push_data (iq_push_data),
        .take      (iq_take),
        .take_pos  (iq_take_pos),
        .rd_pos    (idx_reg[SW-1:0]),
        .rd_data   (iq_rd_data),
        .count     (iq_count)
    );

    assign tbl_rd = tbl_row_t'(tbl_rdata);
    assign dyn_rd = dyn_row_t'(dyn_rdata);

    assign mode_eff  = (mode_reg > MODE_PPRIO) ? MODE_FCFS : mode_reg;
    assign quant_eff = (quant_reg == 8'd0) ? 8'd1 : quant_reg;

    assign slot_ld   = SW'(pidx_reg);
    assign idx_ok    = (32'(pidx_reg) < NUM_PROCS);
    assign scan_slot = idx_reg[SW-1:0];
    assign cpu_fix   = (cpu_in_reg == 8'd0) ? 8'd1 : cpu_in_reg;
    assign req_fix   = (req_in_reg == 8'd0) ? 8'd1 : req_in_reg;
    assign rq_rd_pos = (op == OP_SEL_TAKE) ? best_pos_reg : idx_reg[SW-1:0];

    assign sel_key = ((mode_eff == MODE_SJF) || (mode_eff == MODE_PSJF)) ? dyn_rd.rem :
                     ((mode_eff == MODE_PRIO) || (mode_eff == MODE_PPRIO)) ? tbl_rd.prio :
                     8'd0;

    // one tick of the running process
    assign rem_n     = (dyn_rd.rem != 8'd0) ? dyn_rd.rem - 8'd1 : dyn_rd.rem;
    assign rl_n      = (!dyn_rd.io_taken && (dyn_rd.req_left != 8'd0)) ?
                       dyn_rd.req_left - 8'd1 : dyn_rd.req_left;
    assign slice_inc = (slice_reg != 8'hFF) ? slice_reg + 8'd1 : slice_reg;
    assign tick_inc  = (tick_reg != 16'hFFFF) ? tick_reg + 16'd1 : tick_reg;
    assign arr_ext   = {8'd0, tbl_rd.arr};
    assign tat_c     = (tick_inc >= arr_ext) ? tick_inc - arr_ext : 16'd0;
    assign used_c    = {1'b0, tbl_rd.cpu} + (dyn_rd.io_taken ? {1'b0, tbl_rd.iob} : 9'd0);
    assign wait_c    = (tat_c >= {7'd0, used_c}) ? tat_c - {7'd0, used_c} : 16'd0;
    assign run_pid   = 5'(32'(run_slot_reg) + 1);
    assign il_n      = (dyn_rd.io_left != 8'd0) ? dyn_rd.io_left - 8'd1 : 8'd0;
    assign all_done  = (loaded_reg != '0) && (loaded_reg == done_reg);

    always_comb
    begin
        mode_next      = mode_reg;
        quant_next     = quant_reg;
        status_next    = status_reg;
        tick_next      = tick_reg;
        run_valid_next = run_valid_reg;
        run_slot_next  = run_slot_reg;
        slice_next     = slice_reg;
        loaded_next    = loaded_reg;
        done_next      = done_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        best_pos_next  = best_pos_reg;
        best_key_next  = best_key_reg;
        ran_next       = ran_reg;
        dflag_next     = dflag_reg;
        dpid_next      = dpid_reg;
        tat_next       = tat_reg;
        wait_next      = wait_reg;
        outcome_next   = outcome_reg;
        srem_next      = srem_reg;
        srl_next       = srl_reg;
        siob_next      = siob_reg;
        out_flag_next  = out_flag_reg;
        out_data_next  = out_data_reg;
        tbl_we         = 1'b0;
        tbl_waddr      = slot_ld;
        tbl_wrow       = '{arr: arr_in_reg, cpu: cpu_fix, iob: iob_in_reg,
                           req: req_fix, prio: prio_in_reg};
        tbl_raddr      = scan_slot;
        dyn_we         = 1'b0;
        dyn_waddr      = slot_ld;
        dyn_wrow       = '{rem: cpu_fix, req_left: req_fix, io_left: 8'd0, io_taken: 1'b0};
        dyn_raddr      = run_slot_reg;
        rq_push        = 1'b0;
        rq_push_data   = scan_slot;
        rq_take        = 1'b0;
        rq_take_pos    = idx_reg[SW-1:0];
        iq_push        = 1'b0;
        iq_push_data   = run_slot_reg;
        iq_take        = 1'b0;
        iq_take_pos    = idx_reg[SW-1:0];

        if (cfg_we)
        begin
            if (cfg_index == REG_SCHED_MODE)
            begin
                mode_next = cfg_data[2:0];
            end
            else if (cfg_index == REG_SLICE_LEN)
            begin
                quant_next = cfg_data;
            end
        end

        if (in_accept)
        begin
            ran_next     = 5'd0;
            dflag_next   = 1'b0;
            dpid_next    = 5'd0;
            tat_next     = 16'd0;
            wait_next    = 16'd0;
            outcome_next = OC_NONE;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (op)
            OP_NONE:
            begin
            end
            OP_CLR:
            begin
                idx_next = '0;
            end
            OP_FIND:
            begin
                if (status_reg[slot_ld] == PS_READY)
                begin
                    if (rq_rd_data == slot_ld)
                    begin
                        rq_take = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                else
                begin
                    if (iq_rd_data == slot_ld)
                    begin
                        iq_take = 1'b1;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
            end
            OP_LOAD:
            begin
                tbl_we = 1'b1;
                dyn_we = 1'b1;
                if (status_reg[slot_ld] == PS_EMPTY)
                begin
                    loaded_next = loaded_reg + CW'(1);
                end
                else if (status_reg[slot_ld] == PS_DONE)
                begin
                    done_next = done_reg - CW'(1);
                end
                status_next[slot_ld] = PS_PENDING;
                if (run_valid_reg && (run_slot_reg == slot_ld))
                begin
                    run_valid_next = 1'b0;
                end
            end
            OP_ARR_RD:
            begin
                tbl_raddr = scan_slot;
            end
            OP_ARR_CHK:
            begin
                if ((status_reg[scan_slot] == PS_PENDING) && (arr_ext <= tick_reg))
                begin
                    status_next[scan_slot] = PS_READY;
                    rq_push                = 1'b1;
                    rq_push_data           = scan_slot;
                end
                idx_next = sta.scan_last ? '0 : idx_reg + CW'(1);
            end
            OP_SEL_RD:
            begin
                tbl_raddr = rq_rd_data;
                dyn_raddr = rq_rd_data;
            end
            OP_SEL_CHK:
            begin
                // strict compare keeps the earliest queued entry on a tie
                if ((idx_reg == '0) || (sel_key < best_key_reg))
                begin
                    best_pos_next = idx_reg[SW-1:0];
                    best_key_next = sel_key;
                end
                idx_next = sta.sel_last ? '0 : idx_reg + CW'(1);
            end
            OP_SEL_TAKE:
            begin
                rq_take                 = 1'b1;
                rq_take_pos             = best_pos_reg;
                run_slot_next           = rq_rd_data;
                run_valid_next          = 1'b1;
                slice_next              = 8'd0;
                status_next[rq_rd_data] = PS_RUN;
            end
            OP_RUN_RD:
            begin
                tbl_raddr = run_slot_reg;
                dyn_raddr = run_slot_reg;
            end
            OP_RUN_EX:
            begin
                tick_next = tick_inc;
                if (run_valid_reg)
                begin
                    ran_next   = run_pid;
                    slice_next = slice_inc;
                    srem_next  = rem_n;
                    srl_next   = rl_n;
                    siob_next  = tbl_rd.iob;
                    dyn_we     = 1'b1;
                    dyn_waddr  = run_slot_reg;
                    dyn_wrow   = '{rem: rem_n, req_left: rl_n, io_left: dyn_rd.io_left,
                                   io_taken: dyn_rd.io_taken};
                    if (rem_n == 8'd0)
                    begin
                        status_next[run_slot_reg] = PS_DONE;
                        run_valid_next            = 1'b0;
                        done_next                 = done_reg + CW'(1);
                        dflag_next                = 1'b1;
                        dpid_next                 = run_pid;
                        tat_next                  = tat_c;
                        wait_next                 = wait_c;
                    end
                    else if (!dyn_rd.io_taken && (tbl_rd.iob != 8'd0) && (rl_n == 8'd0))
                    begin
                        outcome_next = OC_IO;
                    end
                    else if (((mode_eff == MODE_RR) && (slice_inc >= quant_eff)) ||
                             (mode_eff == MODE_PSJF) || (mode_eff == MODE_PPRIO))
                    begin
                        outcome_next = OC_PREEMPT;
                    end
                end
            end
            OP_IO_RD:
            begin
                dyn_raddr = iq_rd_data;
            end
            OP_IO_CHK:
            begin
                dyn_we    = 1'b1;
                dyn_waddr = iq_rd_data;
                dyn_wrow  = '{rem: dyn_rd.rem, req_left: dyn_rd.req_left, io_left: il_n,
                              io_taken: dyn_rd.io_taken};
                if (il_n == 8'd0)
                begin
                    status_next[iq_rd_data] = PS_READY;
                    rq_push                 = 1'b1;
                    rq_push_data            = iq_rd_data;
                    iq_take                 = 1'b1;
                end
                else
                begin
                    idx_next = idx_reg + CW'(1);
                end
            end
            OP_POST:
            begin
                unique case (outcome_reg)
                    OC_IO:
                    begin
                        status_next[run_slot_reg] = PS_IO;
                        iq_push                   = 1'b1;
                        run_valid_next            = 1'b0;
                        dyn_we                    = 1'b1;
                        dyn_waddr                 = run_slot_reg;
                        dyn_wrow                  = '{rem: srem_reg, req_left: srl_reg,
                                                      io_left: siob_reg, io_taken: 1'b1};
                    end
                    OC_PREEMPT:
                    begin
                        status_next[run_slot_reg] = PS_READY;
                        rq_push                   = 1'b1;
                        rq_push_data              = run_slot_reg;
                        run_valid_next            = 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            OP_OUT:
            begin
                out_valid_next = 1'b1;
                out_flag_next  = dflag_reg;
                out_data_next  = {5'd0, all_done, wait_reg, tat_reg, dpid_reg, tick_reg,
                                  ran_reg};
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_FCFS;
            quant_reg     <= QUANT_RESET;
            for (int p = 0; p < NUM_PROCS; p++)
            begin
                status_reg[p] <= PS_EMPTY;
            end
            tick_reg      <= '0;
            run_valid_reg <= 1'b0;
            run_slot_reg  <= '0;
            slice_reg     <= '0;
            loaded_reg    <= '0;
            done_reg      <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            outcome_reg   <= OC_NONE;
        end
        else
        begin
            mode_reg      <= mode_next;
            quant_reg     <= quant_next;
            status_reg    <= status_next;
            tick_reg      <= tick_next;
            run_valid_reg <= run_valid_next;
            run_slot_reg  <= run_slot_next;
            slice_reg     <= slice_next;
            loaded_reg    <= loaded_next;
            done_reg      <= done_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            outcome_reg   <= outcome_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            kind_reg    <= in_kind;
            pidx_reg    <= in_data[3:0];
            arr_in_reg  <= in_data[11:4];
            cpu_in_reg  <= in_data[19:12];
            iob_in_reg  <= in_data[27:20];
            req_in_reg  <= in_data[35:28];
            prio_in_reg <= in_data[43:36];
        end
        best_pos_reg <= best_pos_next;
        best_key_reg <= best_key_next;
        ran_reg      <= ran_next;
        dflag_reg    <= dflag_next;
        dpid_reg     <= dpid_next;
        tat_reg      <= tat_next;
        wait_reg     <= wait_next;
        srem_reg     <= srem_next;
        srl_reg      <= srl_next;
        siob_reg     <= siob_next;
        out_flag_reg <= out_flag_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        sta.is_tick     = kind_reg;
        sta.idx_ok      = idx_ok;
        sta.idx_queued  = (status_reg[slot_ld] == PS_READY) ||
                          (status_reg[slot_ld] == PS_IO);
        sta.find_hit    = (status_reg[slot_ld] == PS_READY) ? (rq_rd_data == slot_ld) :
                                                              (iq_rd_data == slot_ld);
        sta.scan_last   = (idx_reg == CW'(NUM_PROCS - 1));
        sta.run_valid   = run_valid_reg;
        sta.ready_empty = (rq_count == '0);
        sta.sel_last    = ((idx_reg + CW'(1)) == rq_count);
        sta.io_end      = (idx_reg >= iq_count);
        sta.out_free    = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_flag  = out_flag_reg;
    assign out_data  = out_data_reg;

endmodule

>>> hdl/cpusch_ctrl.sv
// Controller: sequences the slot scans, selection, run step and I/O walk.
module cpusch_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cpusch_pkg::sta_t   sta,
    output cpusch_pkg::dp_op_t op
);
    import cpusch_pkg::*;

    ctrl_state_t state_reg, state_next;
    logic        pass2_reg, pass2_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pass2_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pass2_reg <= pass2_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pass2_next = pass2_reg;
        op         = OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (sta.is_tick)
                begin
                    op         = OP_CLR;
                    pass2_next = 1'b0;
                    state_next = S_ARR_RD;
                end
                else if (!sta.idx_ok)
                begin
                    state_next = S_OUT;
                end
                else if (sta.idx_queued)
                begin
                    op         = OP_CLR;
                    state_next = S_FIND;
                end
                else
                begin
                    state_next = S_LOAD;
                end
            end
            S_FIND:
            begin
                op = OP_FIND;
                if (sta.find_hit)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                op         = OP_LOAD;
                state_next = S_OUT;
            end
            S_ARR_RD:
            begin
                op         = OP_ARR_RD;
                state_next = S_ARR_CHK;
            end
            S_ARR_CHK:
            begin
                op = OP_ARR_CHK;
                priority if (!sta.scan_last)
                begin
                    state_next = S_ARR_RD;
                end
                else if (pass2_reg)
                begin
                    state_next = S_IO_RD;
                end
                else if (sta.run_valid)
                begin
                    state_next = S_RUN_RD;
                end
                else
                begin
                    state_next = S_SEL_RD;
                end
            end
            S_SEL_RD:
            begin
                // queue count here already holds the last slot's arrival
                if (sta.ready_empty)
                begin
                    state_next = S_RUN_RD;
                end
                else
                begin
                    op         = OP_SEL_RD;
                    state_next = S_SEL_CHK;
                end
            end
            S_SEL_CHK:
            begin
                op         = OP_SEL_CHK;
                state_next = sta.sel_last ? S_SEL_TAKE : S_SEL_RD;
            end
            S_SEL_TAKE:
            begin
                op         = OP_SEL_TAKE;
                state_next = S_RUN_RD;
            end
            S_RUN_RD:
            begin
                op         = OP_RUN_RD;
                state_next = S_RUN_EX;
            end
            S_RUN_EX:
            begin
                op         = OP_RUN_EX;
                pass2_next = 1'b1;
                state_next = S_ARR_RD;
            end
            S_IO_RD:
            begin
                if (sta.io_end)
                begin
                    state_next = S_POST;
                end
                else
                begin
                    op         = OP_IO_RD;
                    state_next = S_IO_CHK;
                end
            end
            S_IO_CHK:
            begin
                op         = OP_IO_CHK;
                state_next = S_IO_RD;
            end
            S_POST:
            begin
                op         = OP_POST;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (sta.out_free)
                begin
                    op         = OP_OUT;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

>>> hdl/cpu_scheduler_tick_engine.sv
// Top level of the CPU scheduler tick engine: controller plus datapath.
//
// Channel | Dir | Handshake                    | Carries
// s_axis  | in  | s_axis_tvalid/s_axis_tready  | one load or tick transaction
// m_axis  | out | m_axis_tvalid/m_axis_tready  | one result per input transaction
// cfg     | in  | cfg_we                       | sched_mode, round robin slice length
//
// A tick runs two arrival scans over all NUM_PROCS slots, each slot read through
// the table RAM read port and then checked, a selection over the R ready entries
// when none runs, one run step and a walk over the Q entries of the I/O queue.
// A load of a slot that is still queued first searches that queue for the slot.
// After reset all slots are empty; the table needs no clearing pass.
// A result waiting in the output register does not hold off the next input;
// a stalled output holds the block only at the end of the following item.
module cpu_scheduler_tick_engine #(
    parameter int NUM_PROCS = cpusch_pkg::NUM_PROCS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [cpusch_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [cpusch_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // proc_index, arrival_tick, cpu_burst, io_burst, io_request_after,
    // prio_level (lowest bit up)
    input  logic [cpusch_pkg::TDATA_IN_W-1:0]   s_axis_tdata,
    // req_type
    input  logic [0:0]                          s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // run_pid, time_now, done_pid, turnaround, wait_ticks, all_done
    // (lowest bit up)
    output logic [cpusch_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    // done_flag
    output logic [0:0]                          m_axis_tuser
);
    import cpusch_pkg::*;

    sta_t   sta;
    dp_op_t op;
    logic   in_accept;

    // a transaction is taken only in the idle state
    assign in_accept = s_axis_tvalid && s_axis_tready;

    cpusch_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .sta      (sta),
        .op       (op)
    );

    cpusch_dp #(.NUM_PROCS(NUM_PROCS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .sta       (sta),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_accept (in_accept),
        .in_kind   (s_axis_tuser[0]),
        .in_data   (s_axis_tdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_flag  (m_axis_tuser[0]),
        .out_data  (m_axis_tdata)
    );

endmodule

>>> hdl/cpusch_checker.sv
// Port-level checker of the scheduler tick engine and its bind.
module cpusch_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                s_axis_tvalid,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [cpusch_pkg::TDATA_OUT_W-1:0]  m_axis_tdata,
    input logic [0:0]                          m_axis_tuser
);

    // stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one transaction in work at a time
    a_in_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while busy");

    // without a completion the completion fields are zero
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |->
        (m_axis_tdata[25:21] == 5'd0) && (m_axis_tdata[41:26] == 16'd0) &&
        (m_axis_tdata[57:42] == 16'd0))
        else $error("completion fields set without done_flag");

    // waiting time never exceeds turnaround
    a_wait_le_tat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[57:42] <= m_axis_tdata[41:26]))
        else $error("wait_ticks above turnaround");

endmodule

bind cpu_scheduler_tick_engine cpusch_checker u_cpusch_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

>>> dv/cpu_scheduler_tick_engine_tb.sv
// Self-checking testbench of the CPU scheduler tick engine.
`timescale 1ns / 1ps

module cpu_scheduler_tick_engine_tb;
    import cpusch_pkg::*;

    localparam int NPROC      = NUM_PROCS_DEF;
    localparam int SETTLE_CYC = 300;      // above the longest tick
    localparam int CYC_LIMIT  = 3000000;
    localparam int RAND_ITEMS = 40;       // per configuration phase

    // one result transaction, field by field
    typedef struct {
        logic [4:0]  run_pid;
        logic [15:0] time_now;
        logic        done_flag;
        logic [4:0]  done_pid;
        logic [15:0] turnaround;
        logic [15:0] wait_ticks;
        logic        all_done;
    } sched_res_t;

    // one request transaction
    typedef struct {
        logic       is_tick;
        logic [3:0] slot;
        logic [7:0] arr;
        logic [7:0] cpu;
        logic [7:0] iob;
        logic [7:0] req;
        logic [7:0] prio;
    } sched_req_t;

    typedef struct {
        sched_req_t rq;
        bit         typed;
        sched_res_t res;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata;
    logic [0:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;
    logic [0:0]             m_axis_tuser;

    cpu_scheduler_tick_engine i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Scheduler shadow: own copy of table, queues, clock and registers
    // ------------------------------------------------------------------
    logic [2:0]  sh_mode;
    logic [7:0]  sh_quant;
    logic [7:0]  sh_arr [NPROC];
    logic [7:0]  sh_cpu [NPROC];
    logic [7:0]  sh_iob [NPROC];
    logic [7:0]  sh_prio [NPROC];
    logic [7:0]  sh_rem [NPROC];
    logic [7:0]  sh_req_left [NPROC];
    logic [7:0]  sh_io_left [NPROC];
    bit          sh_io_taken [NPROC];
    pstat_t      sh_stat [NPROC];
    int          ready_q[$];
    int          io_q[$];
    int unsigned sh_clock;
    bit          sh_running;
    int          sh_run_slot;
    int          sh_slice;

    sched_res_t  expected_q[$];
    int          n_fail;
    int          n_results;
    int          n_done;
    int          n_ticks;
    int          n_loads;

    function automatic void drop_slot(ref int q[$], input int s);
        for (int k = q.size() - 1; k >= 0; k--)
            if (q[k] == s)
                q.delete(k);
    endfunction

    function automatic void admit_arrivals();
        for (int i = 0; i < NPROC; i++)
            if (sh_stat[i] == PS_PENDING && sh_arr[i] <= sh_clock)
            begin
                sh_stat[i] = PS_READY;
                ready_q.push_back(i);
            end
    endfunction

    function automatic int sel_key(logic [2:0] m, int s);
        if (m == MODE_SJF || m == MODE_PSJF)
            return sh_rem[s];
        if (m == MODE_PRIO || m == MODE_PPRIO)
            return sh_prio[s];
        return 0;
    endfunction

    // Result of one request; shadow state is advanced as a side effect.
    function automatic sched_res_t sched_next(sched_req_t rq);
        sched_res_t r;
        logic [2:0] m;
        int         q;
        int         s;
        int         best;
        int         tat;
        int         used;
        outcome_t   oc;
        int         io_keep[$];
        r = '{default: '0};
        m = (sh_mode > MODE_PPRIO) ? MODE_FCFS : sh_mode;
        q = (sh_quant == 0) ? 1 : sh_quant;
        oc = OC_NONE;
        if (!rq.is_tick)
        begin
            s = rq.slot;
            drop_slot(ready_q, s);
            drop_slot(io_q, s);
            if (sh_running && sh_run_slot == s)
                sh_running = 0;
            sh_arr[s]      = rq.arr;
            sh_cpu[s]      = (rq.cpu == 0) ? 8'd1 : rq.cpu;
            sh_iob[s]      = rq.iob;
            sh_req_left[s] = (rq.req == 0) ? 8'd1 : rq.req;
            sh_prio[s]     = rq.prio;
            sh_rem[s]      = sh_cpu[s];
            sh_io_left[s]  = 0;
            sh_io_taken[s] = 0;
            sh_stat[s]     = PS_PENDING;
        end
        else
        begin
            admit_arrivals();
            if (!sh_running && ready_q.size() > 0)
            begin
                best = 0;
                for (int k = 1; k < ready_q.size(); k++)
                    if (sel_key(m, ready_q[k]) < sel_key(m, ready_q[best]))
                        best = k;
                sh_run_slot = ready_q[best];
                ready_q.delete(best);
                sh_running = 1;
                sh_slice = 0;
                sh_stat[sh_run_slot] = PS_RUN;
            end
            s = sh_run_slot;
            if (sh_running)
            begin
                r.run_pid = 5'(s + 1);
                if (sh_rem[s] > 0)
                    sh_rem[s]--;
                if (!sh_io_taken[s] && sh_req_left[s] > 0)
                    sh_req_left[s]--;
                if (sh_slice < 255)
                    sh_slice++;
            end
            if (sh_clock < 65535)
                sh_clock++;
            if (sh_running)
            begin
                if (sh_rem[s] == 0)
                begin
                    tat  = (sh_clock >= sh_arr[s]) ? sh_clock - sh_arr[s] : 0;
                    used = sh_cpu[s] + (sh_io_taken[s] ? sh_iob[s] : 0);
                    sh_stat[s] = PS_DONE;
                    sh_running = 0;
                    r.done_flag  = 1;
                    r.done_pid   = 5'(s + 1);
                    r.turnaround = 16'(tat);
                    r.wait_ticks = 16'((tat >= used) ? tat - used : 0);
                end
                else if (!sh_io_taken[s] && sh_iob[s] > 0 && sh_req_left[s] == 0)
                    oc = OC_IO;
                else if ((m == MODE_RR && sh_slice >= q) || m == MODE_PSJF
                         || m == MODE_PPRIO)
                    oc = OC_PREEMPT;
            end
            admit_arrivals();
            // I/O countdown: finished entries rejoin the ready tail in queue order
            foreach (io_q[k])
            begin
                if (sh_io_left[io_q[k]] > 0)
                    sh_io_left[io_q[k]]--;
                if (sh_io_left[io_q[k]] == 0)
                begin
                    sh_stat[io_q[k]] = PS_READY;
                    ready_q.push_back(io_q[k]);
                end
                else
                    io_keep.push_back(io_q[k]);
            end
            io_q = io_keep;
            if (oc == OC_IO)
            begin
                sh_io_taken[s] = 1;
                sh_io_left[s]  = sh_iob[s];
                sh_stat[s]     = PS_IO;
                io_q.push_back(s);
                sh_running = 0;
            end
            else if (oc == OC_PREEMPT)
            begin
                sh_stat[s] = PS_READY;
                ready_q.push_back(s);
                sh_running = 0;
            end
        end
        r.time_now = 16'(sh_clock);
        r.all_done = 1'b0;
        begin
            int loaded;
            bit open_work;
            loaded = 0;
            open_work = 0;
            for (int i = 0; i < NPROC; i++)
                if (sh_stat[i] != PS_EMPTY)
                begin
                    loaded++;
                    if (sh_stat[i] != PS_DONE)
                        open_work = 1;
                end
            r.all_done = (loaded > 0) && !open_work;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: everything changes on the falling edge
    // ------------------------------------------------------------------
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_go;
    bit hold_done;
    int hold_left;

    // receiver, with one long hold-off to back the block up
    always @(negedge clk)
    begin
        if (hold_go && !hold_done)
        begin
            hold_done = 1;
            hold_left = 400;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready = 1'b0;
        end
        else
            m_axis_tready = ($urandom_range(99) >= recv_stall_pct);
    end

    // result checker, sampling on the rising edge
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            sched_res_t got;
            sched_res_t want;
            got.run_pid    = m_axis_tdata[4:0];
            got.time_now   = m_axis_tdata[20:5];
            got.done_pid   = m_axis_tdata[25:21];
            got.turnaround = m_axis_tdata[41:26];
            got.wait_ticks = m_axis_tdata[57:42];
            got.all_done   = m_axis_tdata[58];
            got.done_flag  = m_axis_tuser[0];
            n_results++;
            if (expected_q.size() == 0)
            begin
                $error("result transaction with nothing expected");
                n_fail++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (got.done_flag)
                    n_done++;
                if (got.run_pid !== want.run_pid)
                begin
                    $error("run_pid: expected %0d, got %0d", want.run_pid, got.run_pid);
                    n_fail++;
                end
                if (got.time_now !== want.time_now)
                begin
                    $error("time_now: expected %0d, got %0d", want.time_now, got.time_now);
                    n_fail++;
                end
                if (got.done_flag !== want.done_flag)
                begin
                    $error("done_flag: expected %0d, got %0d", want.done_flag,
                           got.done_flag);
                    n_fail++;
                end
                if (got.done_pid !== want.done_pid)
                begin
                    $error("done_pid: expected %0d, got %0d", want.done_pid, got.done_pid);
                    n_fail++;
                end
                if (got.turnaround !== want.turnaround)
                begin
                    $error("turnaround: expected %0d, got %0d", want.turnaround,
                           got.turnaround);
                    n_fail++;
                end
                if (got.wait_ticks !== want.wait_ticks)
                begin
                    $error("wait_ticks: expected %0d, got %0d", want.wait_ticks,
                           got.wait_ticks);
                    n_fail++;
                end
                if (got.all_done !== want.all_done)
                begin
                    $error("all_done: expected %0d, got %0d", want.all_done, got.all_done);
                    n_fail++;
                end
            end
        end
    end

    // watchdog
    int cyc;
    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYC_LIMIT)
        begin
            $display("timeout after %0d cycles", cyc);
            $display("cpu_scheduler_tick_engine test failed");
            $finish;
        end
    end

    // one request transaction; prediction taken at acceptance
    task automatic send_req(sched_req_t rq, bit typed, sched_res_t typed_res);
        sched_res_t pred;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid = 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = rq.is_tick;
        s_axis_tdata  = '0;
        s_axis_tdata[43:0] = {rq.prio, rq.req, rq.iob, rq.cpu, rq.arr, rq.slot};
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = sched_next(rq);
        expected_q.push_back(typed ? typed_res : pred);
        if (rq.is_tick)
            n_ticks++;
        else
            n_loads++;
        @(negedge clk);
        s_axis_tvalid = 1'b0;
    endtask

    // wait for the block to go quiet, then write one register
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        if (idx == REG_SCHED_MODE)
            sh_mode = val[2:0];
        else
            sh_quant = val;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    function automatic sched_req_t rand_req();
        sched_req_t rq;
        rq.is_tick = ($urandom_range(99) >= 30);
        rq.slot    = 4'($urandom_range(NPROC - 1));
        if ($urandom_range(9) == 0)
        begin
            // wide-open content: every bit of every field
            rq.arr  = 8'($urandom);
            rq.cpu  = 8'($urandom);
            rq.iob  = 8'($urandom);
            rq.req  = 8'($urandom);
            rq.prio = 8'($urandom);
        end
        else
        begin
            rq.arr  = 8'($urandom_range(40));
            rq.cpu  = 8'($urandom_range(1, 8));
            rq.iob  = ($urandom_range(2) == 0) ? 8'd0 : 8'($urandom_range(1, 5));
            rq.req  = 8'($urandom_range(1, 4));
            rq.prio = 8'($urandom_range(15));
        end
        return rq;
    endfunction

    dir_row_t dir_tab[$];

    task automatic add_row(bit tk, int sl, int ar, int cp, int io, int rqa, int pr,
                           bit typed = 0, sched_res_t res = '{default: '0});
        dir_row_t row;
        row.rq    = '{tk, 4'(sl), 8'(ar), 8'(cp), 8'(io), 8'(rqa), 8'(pr)};
        row.typed = typed;
        row.res   = res;
        dir_tab.push_back(row);
    endtask

    // mode / quantum pairs per phase; extremes and the out-of-range modes included
    int ph_mode[11]  = '{0, 1, 2, 3, 3, 3, 3, 4, 5, 6, 7};
    int ph_quant[11] = '{2, 255, 1, 0, 1, 3, 255, 2, 2, 5, 2};

    initial
    begin
        sched_req_t no_req;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_go = 0;
        hold_done = 0;
        hold_left = 0;
        n_fail = 0;
        n_results = 0;
        n_done = 0;
        n_ticks = 0;
        n_loads = 0;
        cyc = 0;
        sh_mode = MODE_FCFS;
        sh_quant = QUANT_RESET;
        sh_clock = 0;
        sh_running = 0;
        sh_run_slot = 0;
        sh_slice = 0;
        for (int i = 0; i < NPROC; i++)
        begin
            sh_stat[i] = PS_EMPTY;
            sh_io_taken[i] = 0;
        end
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: first load after reset, then a one-tick job finishing at once
        add_row(0, 0, 0, 1, 0, 1, 0, 1, '{default: '0});
        add_row(1, 0, 0, 0, 0, 0, 0, 1, '{5'd1, 16'd1, 1'b1, 5'd1, 16'd1, 16'd0, 1'b1});
        add_row(0, 15, 255, 255, 255, 255, 255);   // all fields at their top
        add_row(0, 1, 0, 0, 3, 0, 0);              // zero cpu burst, zero request time
        add_row(0, 2, 1, 4, 2, 2, 7);
        for (int k = 0; k < 7; k++)
            add_row(1, 0, 0, 0, 0, 0, 0);
        add_row(0, 2, 0, 2, 0, 1, 3);              // reload a queued/running slot
        add_row(0, 15, 0, 3, 1, 1, 255);           // reload the extreme slot
        for (int k = 0; k < 8; k++)
            add_row(1, 0, 0, 0, 0, 0, 0);
        foreach (dir_tab[k])
            send_req(dir_tab[k].rq, dir_tab[k].typed, dir_tab[k].res);

        // random phases, one mode/quantum setting each
        for (int ph = 0; ph < 11; ph++)
        begin
            write_reg(REG_SCHED_MODE, 8'(ph_mode[ph]));
            write_reg(REG_SLICE_LEN, 8'(ph_quant[ph]));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 29; recv_stall_pct = 29; end
            endcase
            if (ph == 4)
                hold_go = 1;
            for (int k = 0; k < RAND_ITEMS; k++)
                send_req(rand_req(), 0, '{default: '0});
        end

        while (expected_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);

        $display("covered %0d loads and %0d ticks over 11 mode/quantum settings",
                 n_loads, n_ticks);
        $display("%0d results checked, %0d completions, %0d mismatches",
                 n_results, n_done, n_fail);
        if (n_fail == 0 && expected_q.size() == 0)
            $display("cpu_scheduler_tick_engine test passed");
        else
            $display("cpu_scheduler_tick_engine test failed");
        $finish;
    end

endmodule

>>> sim.f
hdl/cpusch_pkg.sv
hdl/cpusch_ram.sv
hdl/cpusch_queue.sv
hdl/cpusch_dp.sv
hdl/cpusch_ctrl.sv
hdl/cpu_scheduler_tick_engine.sv
hdl/cpusch_checker.sv
dv/cpu_scheduler_tick_engine_tb.sv
